[sv/bpa_pkg.sv]
// Shared types and constants for the bitmap page allocator.
// No dependencies; every file but bpa_ram imports this package.
package bpa_pkg;

  localparam int MAX_PAGES   = 4096;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int PAGE_W      = $clog2(MAX_PAGES);
  localparam int CNT_W       = PAGE_W + 1;
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WADDR_W     = $clog2(MAP_WORDS);
  localparam int FLIP_W      = BIT_W + 1;
  localparam int OP_W        = 2;
  localparam int STS_W       = 2;
  localparam int IN_TDATA_W  = ((PAGE_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PAGE_W + 2 * CNT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_RUN_FREE = 2'd2,
    OP_RUN_USED = 2'd3
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_RANGE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ALU_FIND,
    ALU_SET,
    ALU_CLR
  } alu_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_MODIFY,
    S_DONE
  } state_e;

  typedef struct packed {
    alu_mode_e            mode;
    logic [WADDR_W-1:0]   addr;
    logic [PAGE_W-1:0]    lo;
    logic [CNT_W-1:0]     end_pg;
    logic [WORD_BITS-1:0] data;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] data;
    logic [FLIP_W-1:0]    flips;
    logic                 found;
    logic [BIT_W-1:0]     bit_idx;
  } alu_rsp_t;

endpackage

[sv/bpa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/bpa_word_alu.sv]
// Shared word unit: range mask, first-clear search, set/clear and flip count.
// Depends on bpa_pkg.
module bpa_word_alu (
  input  bpa_pkg::alu_req_t req_i,
  output bpa_pkg::alu_rsp_t rsp_o
);
  import bpa_pkg::*;

  logic [BIT_W-1:0]     lo_sh;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] first_one;
  logic [WORD_BITS-1:0] flip_bits;
  logic [BIT_W-1:0]     bit_idx;
  logic [FLIP_W-1:0]    lvl [BIT_W+1][WORD_BITS];

  always_comb begin
    // Pages inside [lo, end_pg) that fall in this word
    lo_sh   = (req_i.lo[PAGE_W-1:BIT_W] == req_i.addr) ? req_i.lo[BIT_W-1:0] : '0;
    lo_mask = {WORD_BITS{1'b1}} << lo_sh;
    if (req_i.end_pg[CNT_W-1:BIT_W] == {1'b0, req_i.addr}) begin
      hi_mask = ~({WORD_BITS{1'b1}} << req_i.end_pg[BIT_W-1:0]);
    end else begin
      hi_mask = {WORD_BITS{1'b1}};
    end
    mask = lo_mask & hi_mask;

    // Isolate the lowest clear page in range
    free_bits = ~req_i.data & mask;
    first_one = free_bits & (~free_bits + WORD_BITS'(1));
    bit_idx   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (first_one[b]) begin
        bit_idx = bit_idx | BIT_W'(b);
      end
    end

    rsp_o.found   = |free_bits;
    rsp_o.bit_idx = bit_idx;

    case (req_i.mode)
      ALU_FIND: begin
        rsp_o.data = req_i.data | first_one;
        flip_bits  = first_one;
      end
      ALU_SET: begin
        rsp_o.data = req_i.data | mask;
        flip_bits  = mask & ~req_i.data;
      end
      ALU_CLR: begin
        rsp_o.data = req_i.data & ~mask;
        flip_bits  = mask & req_i.data;
      end
      default: begin
        rsp_o.data = req_i.data;
        flip_bits  = '0;
      end
    endcase

    // Adder tree for the flip count
    for (int l = 0; l <= BIT_W; l++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        lvl[l][i] = '0;
      end
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      lvl[0][i] = FLIP_W'(flip_bits[i]);
    end
    for (int l = 1; l <= BIT_W; l++) begin
      for (int i = 0; i < (WORD_BITS >> l); i++) begin
        lvl[l][i] = lvl[l-1][2*i] + lvl[l-1][2*i+1];
      end
    end
    rsp_o.flips = lvl[BIT_W][0];
  end

endmodule

[sv/bitmap_page_allocator_top.sv]
// Top level of the bitmap page allocator: sequencer, count and map valid bits.
// Depends on bpa_pkg, bpa_ram and bpa_word_alu.
//
// Usage: write the page total once on the cfg channel (cfg_valid_i/cfg_ready_o,
// cfg_data_i); this marks every page used and loads the used count with the
// total (saturated to the map capacity). Requests enter on s_axis: tuser holds
// the operation (allocate, free page, mark run free, mark run used), tdata the
// page index and run length. Each request gives one transfer on m_axis: tuser
// holds the status, tdata the granted page, pages in use and pages free.
// Scan: the map is held in a RAM and one map word passes the word unit per
// cycle. An allocate scans from word 0 to the first clear page (at most 128
// words); a free touches one word, a run the words it spans; rejected or
// empty requests skip the map. One request is in progress at a time;
// s_axis_tready is high only while idle.
// Reset: map reads as all used (per-word valid bits), count and total zero.
// Stalls: a finished result waits in the output register while the next
// request is taken; a further result holds until m_axis_tready frees it.
module bitmap_page_allocator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write: page total
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bpa_pkg::CNT_W-1:0]          cfg_data_i,
  // requests
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bpa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // page_index, page_count, zero fill
  input  logic [bpa_pkg::OP_W-1:0]           s_axis_tuser,  // operation
  // results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bpa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // granted_page, pages_in_use,
                                                            // pages_free, zero fill
  output logic [bpa_pkg::STS_W-1:0]          m_axis_tuser   // status
);
  import bpa_pkg::*;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [PAGE_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [WADDR_W-1:0]   word_q, word_d;
  logic [PAGE_W-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]     end_q, end_d;
  logic [CNT_W-1:0]     tot_q, tot_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [MAP_WORDS-1:0] vld_q, vld_d;
  status_e              status_q, status_d;
  logic [PAGE_W-1:0]    grant_q, grant_d;
  logic [WADDR_W-1:0]   rd_addr_q;

  logic                 out_vld_q, out_vld_d;
  logic                 out_load;
  status_e              out_status_q;
  logic [PAGE_W-1:0]    out_grant_q;
  logic [CNT_W-1:0]     out_used_q;
  logic [CNT_W-1:0]     out_free_q;

  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] map_word;
  logic [CNT_W-1:0]     cfg_sat;
  logic [CNT_W:0]       run_end;
  logic [CNT_W-1:0]     end_m1;
  logic                 last_word;
  logic [CNT_W-1:0]     flips_ext;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (alu_rsp.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bpa_word_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Words never written since the last fill read as all used
  assign map_word = vld_q[rd_addr_q] ? ram_rdata : {WORD_BITS{1'b1}};

  always_comb begin
    unique case (op_q) inside
      OP_ALLOC:              alu_req.mode = ALU_FIND;
      OP_RUN_USED:           alu_req.mode = ALU_SET;
      OP_FREE, OP_RUN_FREE:  alu_req.mode = ALU_CLR;
    endcase
    alu_req.addr   = word_q;
    alu_req.lo     = lo_q;
    alu_req.end_pg = end_q;
    alu_req.data   = map_word;
  end

  assign cfg_sat   = (cfg_data_i > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : cfg_data_i;
  assign run_end   = {2'b00, idx_q} + {1'b0, cnt_q};
  assign end_m1    = end_q - CNT_W'(1);
  assign last_word = (word_q == end_m1[PAGE_W-1:BIT_W]);
  assign flips_ext = CNT_W'(alu_rsp.flips);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    word_d    = word_q;
    lo_d      = lo_q;
    end_d     = end_q;
    tot_d     = tot_q;
    used_d    = used_q;
    vld_d     = vld_q;
    status_d  = status_q;
    grant_d   = grant_q;
    out_vld_d = out_vld_q & ~m_axis_tready;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = word_q;
    s_axis_tready = 1'b0;
    cfg_ready_o   = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (cfg_valid_i) begin
          // refill: every page used, count equals total
          tot_d  = cfg_sat;
          used_d = cfg_sat;
          vld_d  = '0;
        end
        if (s_axis_tvalid) begin
          op_d     = op_e'(s_axis_tuser);
          idx_d    = s_axis_tdata[PAGE_W-1:0];
          cnt_d    = s_axis_tdata[PAGE_W+CNT_W-1:PAGE_W];
          status_d = STS_OK;
          grant_d  = '0;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (op_q) inside
          OP_ALLOC: begin
            if (used_q < tot_q) begin
              lo_d    = '0;
              end_d   = tot_q;
              word_d  = '0;
              state_d = S_READ;
            end else begin
              status_d = STS_NO_FREE;
              state_d  = S_DONE;
            end
          end
          OP_FREE: begin
            if ({1'b0, idx_q} >= tot_q) begin
              status_d = STS_RANGE;
              state_d  = S_DONE;
            end else begin
              lo_d    = idx_q;
              end_d   = {1'b0, idx_q} + CNT_W'(1);
              word_d  = idx_q[PAGE_W-1:BIT_W];
              state_d = S_READ;
            end
          end
          OP_RUN_FREE, OP_RUN_USED: begin
            if (run_end > {1'b0, tot_q}) begin
              status_d = STS_RANGE;
              state_d  = S_DONE;
            end else if (cnt_q == '0) begin
              state_d = S_DONE;
            end else begin
              lo_d    = idx_q;
              end_d   = run_end[CNT_W-1:0];
              word_d  = idx_q[PAGE_W-1:BIT_W];
              state_d = S_READ;
            end
          end
        endcase
      end
      S_READ: begin
        state_d = S_MODIFY;
      end
      S_MODIFY: begin
        // write back this word and fetch the next one in the same cycle
        ram_we        = 1'b1;
        ram_raddr     = word_q + WADDR_W'(1);
        vld_d[word_q] = 1'b1;
        if (alu_req.mode == ALU_CLR) begin
          used_d = used_q - flips_ext;
        end else begin
          used_d = used_q + flips_ext;
        end
        if (op_q == OP_ALLOC && alu_rsp.found) begin
          grant_d = {word_q, alu_rsp.bit_idx};
          state_d = S_DONE;
        end else if (last_word) begin
          if (op_q == OP_ALLOC) begin
            status_d = STS_NO_FREE;
          end
          state_d = S_DONE;
        end else begin
          word_d = word_q + WADDR_W'(1);
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_vld_q || m_axis_tready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_ALLOC;
      word_q    <= '0;
      tot_q     <= '0;
      used_q    <= '0;
      vld_q     <= '0;
      status_q  <= STS_OK;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      word_q    <= word_d;
      tot_q     <= tot_d;
      used_q    <= used_d;
      vld_q     <= vld_d;
      status_q  <= status_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    lo_q      <= lo_d;
    end_q     <= end_d;
    grant_q   <= grant_d;
    rd_addr_q <= ram_raddr;
    if (out_load) begin
      out_status_q <= status_q;
      out_grant_q  <= grant_q;
      out_used_q   <= used_q;
      out_free_q   <= tot_q - used_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - PAGE_W - 2 * CNT_W)'(0),
                          out_free_q, out_used_q, out_grant_q};

`ifndef NO_ASSERTIONS
  a_used_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= tot_q)
    else $error("used count above page total");

  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MODIFY && op_q == OP_ALLOC && alu_rsp.found)
      |-> ({1'b0, word_q, alu_rsp.bit_idx} < tot_q))
    else $error("allocate granted a page beyond the total");

  a_clear_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MODIFY && alu_req.mode == ALU_CLR) |-> (flips_ext <= used_q))
    else $error("free would take the used count below zero");

  a_cfg_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (used_q == tot_q && vld_q == '0))
    else $error("configuration write did not refill the map");
`endif

endmodule

[sim/bitmap_page_allocator_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_page_allocator_top: directed and random requests
// against a page-map predictor kept in a small scoreboard class. Depends on bpa_pkg.
module bitmap_page_allocator_top_tb;
  import bpa_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;  // cycles with no transfer at all
  localparam int unsigned PHASE_ITEMS = 90;
  localparam int unsigned N_PHASES    = 9;

  // One expected answer of the block.
  typedef struct {
    status_e           status;
    logic [PAGE_W-1:0] granted;
    logic [CNT_W-1:0]  in_use;
    logic [CNT_W-1:0]  spare;
  } answer_t;

  // Page map, used count and page total as the block should hold them, plus the
  // answers still owed.
  class page_ledger;
    bit [MAX_PAGES-1:0] used_map;
    int unsigned        used_pages;
    int unsigned        page_total;
    answer_t            pending[$];
    int unsigned        fail_count, n_requests, n_answers, n_totals;
    int unsigned        n_grants, n_full, n_range;

    function new();
      used_map   = '1;
      used_pages = 0;
      page_total = 0;
    endfunction

    // A total write re-initialises the whole map to used.
    function void load_total(logic [CNT_W-1:0] v);
      page_total = (v > MAX_PAGES) ? MAX_PAGES : v;
      used_map   = '1;
      used_pages = page_total;
      n_totals++;
    endfunction

    // Flip one page; the count moves only on an actual flip.
    function void mark(int unsigned p, bit to_used);
      if (used_map[p] == to_used) return;
      used_map[p] = to_used;
      if (to_used) used_pages++;
      else used_pages--;
    endfunction

    function void note_request(op_e op, logic [PAGE_W-1:0] idx, logic [CNT_W-1:0] cnt);
      answer_t     a;
      int unsigned p;
      a.status  = STS_OK;
      a.granted = '0;
      n_requests++;
      case (op)
        OP_ALLOC: begin
          p = 0;
          if (used_pages < page_total)
            while (p < page_total && used_map[p]) p++;
          if (used_pages < page_total && p < page_total) begin
            mark(p, 1'b1);
            a.granted = p[PAGE_W-1:0];
            n_grants++;
          end else begin
            a.status = STS_NO_FREE;
          end
        end
        OP_FREE: begin
          if (idx >= page_total) a.status = STS_RANGE;
          else mark(idx, 1'b0);
        end
        default: begin
          if (int'(idx) + int'(cnt) > page_total) begin
            a.status = STS_RANGE;
          end else begin
            for (p = 0; p < cnt; p++) mark(idx + p, op == OP_RUN_USED);
          end
        end
      endcase
      if (a.status == STS_NO_FREE) n_full++;
      if (a.status == STS_RANGE) n_range++;
      a.in_use = CNT_W'(used_pages);
      a.spare  = CNT_W'(page_total - used_pages);
      pending.push_back(a);
    endfunction

    task report(string what);
      fail_count++;
      if (fail_count <= 40) $display("ERROR at %0t: %s", $time, what);
    endtask

    task check_answer(logic [STS_W-1:0] st, logic [PAGE_W-1:0] g,
                      logic [CNT_W-1:0] u, logic [CNT_W-1:0] f);
      answer_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing owed: status %0d page %0d", st, g));
        return;
      end
      want = pending.pop_front();
      n_answers++;
      if (st !== want.status)
        report($sformatf("answer %0d status %0d, want %0d", n_answers, st, want.status));
      if (g !== want.granted)
        report($sformatf("answer %0d granted page %0d, want %0d", n_answers, g, want.granted));
      if (u !== want.in_use)
        report($sformatf("answer %0d pages in use %0d, want %0d", n_answers, u, want.in_use));
      if (f !== want.spare)
        report($sformatf("answer %0d pages free %0d, want %0d", n_answers, f, want.spare));
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data   = '0;
  logic                   req_valid  = 1'b0;
  logic                   req_ready;
  logic [IN_TDATA_W-1:0]  req_data   = '0;
  logic [OP_W-1:0]        req_op     = '0;
  logic                   rsp_valid;
  logic                   rsp_ready  = 1'b0;
  logic [OUT_TDATA_W-1:0] rsp_data;
  logic [STS_W-1:0]       rsp_status;

  page_ledger  ledger = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet = 0;

  bitmap_page_allocator_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (req_valid),
    .s_axis_tready (req_ready),
    .s_axis_tdata  (req_data),
    .s_axis_tuser  (req_op),
    .m_axis_tvalid (rsp_valid),
    .m_axis_tready (rsp_ready),
    .m_axis_tdata  (rsp_data),
    .m_axis_tuser  (rsp_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Receiver back-pressure: redraw tready every cycle at the current idle rate.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check every result transfer against the oldest owed answer.
  // Fields in tdata from bit 0 up: granted page, pages in use, pages free.
  always @(posedge clk) begin
    if (rst_n && rsp_valid && rsp_ready)
      ledger.check_answer(rsp_status, rsp_data[PAGE_W-1:0], rsp_data[PAGE_W +: CNT_W],
                          rsp_data[PAGE_W+CNT_W +: CNT_W]);
  end

  // Watchdog: end the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Drop tvalid at random, at the current idle rate, before the next request.
  task automatic hold_off_sender();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Present one request and hold it until the transfer; note it once accepted.
  task automatic send_request(op_e op, logic [PAGE_W-1:0] idx, logic [CNT_W-1:0] cnt);
    hold_off_sender();
    req_valid <= 1'b1;
    req_op    <= op;
    req_data  <= IN_TDATA_W'({cnt, idx});  // page_index low, page_count above it
    do @(posedge clk); while (!req_ready);
    ledger.note_request(op, idx, cnt);
  endtask

  // Hold the sender back until every owed answer has come home.
  task automatic settle_requests();
    req_valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
  endtask

  // Write the page total; only called with the block idle.
  task automatic write_total(logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.load_total(v);
  endtask

  // Mostly well-formed requests inside the managed range, some just beyond it,
  // and some pure noise across the full field widths.
  task automatic random_request();
    int unsigned t, r, idx, cnt, room, low;
    op_e         op;
    t   = ledger.page_total;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, 4095);
    cnt = $urandom_range(0, 8191);
    op  = op_e'($urandom_range(0, 3));
    if (t != 0 && r < 35) begin
      op = OP_ALLOC;  // idx and cnt stay random; the block ignores them
    end else if (t != 0 && r < 80) begin
      op   = (r < 55) ? OP_FREE : ((r < 70) ? OP_RUN_FREE : OP_RUN_USED);
      low  = (t < 64) ? t : 64;
      // favour the low pages, where first-fit allocations cluster
      idx  = ($urandom_range(0, 1) != 0) ? $urandom_range(0, low - 1) : $urandom_range(0, t - 1);
      room = t - idx;
      cnt  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, (room < 40) ? room : 40)
                                        : $urandom_range(0, room);
    end else if (t != 0 && r < 90) begin
      if (t < MAX_PAGES && $urandom_range(0, 1) != 0) begin
        op  = OP_FREE;
        idx = $urandom_range(t, 4095);
      end else begin
        op  = ($urandom_range(0, 1) != 0) ? OP_RUN_FREE : OP_RUN_USED;
        idx = $urandom_range(0, t - 1);
        cnt = t - idx + $urandom_range(1, 8);  // one past the end or a little more
      end
    end
    send_request(op, idx[PAGE_W-1:0], cnt[CNT_W-1:0]);
  endtask

  initial begin
    int unsigned phase_totals[N_PHASES];
    phase_totals = '{4096, 37, 1, 300, 8191, 32, 0, 0, 0};
    phase_totals[6] = $urandom_range(2, 4095);
    phase_totals[7] = $urandom_range(4097, 8190);

    // Hold reset low, then release it at a rising edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Straight out of reset the total is zero: every page is
    // out of range and an allocate finds nothing.
    send_request(OP_ALLOC,    12'd0,    13'd0);
    send_request(OP_FREE,     12'd0,    13'd0);
    send_request(OP_RUN_FREE, 12'd0,    13'd0);     // empty run at the edge
    send_request(OP_RUN_USED, 12'd4095, 13'd8191);  // run far beyond the total
    settle_requests();

    // Full capacity: free the whole map, grant, free, refill to full.
    write_total(13'd4096);
    send_request(OP_RUN_FREE, 12'd0,    13'd4096);
    send_request(OP_ALLOC,    12'd4095, 13'd8191);
    send_request(OP_ALLOC,    12'd0,    13'd0);
    send_request(OP_FREE,     12'd4095, 13'd0);     // page already free
    send_request(OP_RUN_USED, 12'd4095, 13'd1);
    send_request(OP_FREE,     12'd4095, 13'd0);
    send_request(OP_FREE,     12'd1,    13'd0);
    send_request(OP_FREE,     12'd1,    13'd0);     // freeing a free page
    send_request(OP_RUN_USED, 12'd0,    13'd4096);  // some pages already used
    send_request(OP_ALLOC,    12'd0,    13'd0);     // map full
    send_request(OP_RUN_FREE, 12'd4095, 13'd2);     // run crosses the end
    send_request(OP_RUN_USED, 12'd4095, 13'd0);     // empty run
    send_request(OP_RUN_FREE, 12'd2048, 13'd2048);
    send_request(OP_ALLOC,    12'd0,    13'd0);
    settle_requests();

    // Total above capacity saturates to the map size.
    write_total(13'd8191);
    send_request(OP_ALLOC,    12'd0,    13'd0);
    send_request(OP_FREE,     12'd4095, 13'd0);
    send_request(OP_ALLOC,    12'd0,    13'd0);
    settle_requests();

    // Random part: one total per phase, idle rates swapped part way through
    // and switched off for the last phases.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct = (ph < 3) ? 29 : ((ph < 6) ? 72 : 0);
      recv_idle_pct = (ph < 3) ? 72 : ((ph < 6) ? 29 : 0);
      write_total(phase_totals[ph][CNT_W-1:0]);
      if (ledger.page_total != 0)
        send_request(OP_RUN_FREE, '0, CNT_W'(ledger.page_total));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) settle_requests();  // let the pipe run dry once
        random_request();
      end
      settle_requests();
    end

    // Allow for anything late or spurious before the verdict.
    repeat (300) @(posedge clk);
    if (ledger.pending.size() != 0)
      ledger.report($sformatf("%0d answers never arrived", ledger.pending.size()));

    $display("Summary: %0d requests under %0d page totals, %0d results checked",
             ledger.n_requests, ledger.n_totals, ledger.n_answers);
    $display("Summary: %0d pages granted, %0d allocates on a full map, %0d range rejects",
             ledger.n_grants, ledger.n_full, ledger.n_range);
    if (ledger.fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
